// File: rtl/scrolling_bar_graph_renderer_assert.svh
// Assertion macros used by the RTL of the scrolling bar graph renderer.
`ifndef SCROLLING_BAR_GRAPH_RENDERER_ASSERT_SVH
`define SCROLLING_BAR_GRAPH_RENDERER_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define SBGR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequence must hold in the cycle after the condition.
`define SBGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sbgr_pkg.sv
package sbgr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int DIM_W       = 11;
   localparam int COORD_W     = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int DEFAULT_HISTORY_DEPTH = 256;

   localparam logic [SAMPLE_W-1:0] MAX_VALUE_RESET    = 16'hFFFF;
   localparam logic [DIM_W-1:0]    GRAPH_WIDTH_RESET  = 11'd256;
   localparam logic [DIM_W-1:0]    GRAPH_HEIGHT_RESET = 11'd256;

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_VALUE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRAPH_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GRAPH_HEIGHT = 2'd2;

   localparam logic MODE_PUSH  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

endpackage

// File: rtl/scrolling_bar_graph_renderer.sv
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall mode, sample, column, row
// rsp       out        rsp_valid/rsp_stall pixel_lit, column_average
// csr       in         csr_write_enable    csr_index, csr_write_data
//
// A push writes the history RAM as it is taken. A query scans the history one entry
// a cycle, stopping early once the scan passes the queried column, then runs the
// shared divider up to twice, for the column average and for the bar height.
// After reset a clearing pass writes zeros to all HISTORY_DEPTH entries of the
// history RAM; no request is taken until it ends.
// The result sits in an output register; a new request is taken while it waits,
// and a finished query holds until the previous result has been taken.
`include "scrolling_bar_graph_renderer_assert.svh"

module scrolling_bar_graph_renderer #(
   parameter int HISTORY_DEPTH = sbgr_pkg::DEFAULT_HISTORY_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [sbgr_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic [sbgr_pkg::COORD_W-1:0]       req_column,
   input  logic [sbgr_pkg::COORD_W-1:0]       req_row,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_pixel_lit,
   output logic [sbgr_pkg::SAMPLE_W-1:0]      rsp_column_average,
   input  logic                               csr_write_enable,
   input  logic [sbgr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sbgr_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = sbgr_pkg::SAMPLE_W + CNT_W;
   localparam int ACC_W  = AW + sbgr_pkg::DIM_W + 1;
   localparam int PROD_W = sbgr_pkg::SAMPLE_W + sbgr_pkg::DIM_W;
   localparam int DVD_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int DVS_W  = (CNT_W > sbgr_pkg::SAMPLE_W) ? CNT_W : sbgr_pkg::SAMPLE_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_AVG,
      ST_AVG_WAIT,
      ST_MUL,
      ST_BAR,
      ST_BAR_WAIT,
      ST_DONE
   } state_type;

   // Configuration registers.
   logic [sbgr_pkg::SAMPLE_W-1:0] max_value_ff;
   logic [sbgr_pkg::DIM_W-1:0]    graph_width_ff;
   logic [sbgr_pkg::DIM_W-1:0]    graph_height_ff;

   state_type                     state_ff, state_in;
   logic [AW-1:0]                 idx_ff, idx_in;
   logic [AW-1:0]                 oldest_ff, oldest_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic [ACC_W-1:0]              lo_ff, lo_in;
   logic [ACC_W-1:0]              hi_ff, hi_in;
   logic                          match_ff, match_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [sbgr_pkg::SAMPLE_W-1:0] avg_ff, avg_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [sbgr_pkg::COORD_W-1:0]  row_ff, row_in;
   logic                          lit_ff, lit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_pixel_lit_ff, rsp_pixel_lit_in;
   logic [sbgr_pkg::SAMPLE_W-1:0] rsp_column_average_ff, rsp_column_average_in;

   logic                          req_accept;
   logic [AW-1:0]                 oldest_next;
   logic [AW:0]                   slot_sum;
   logic [AW-1:0]                 slot;
   logic [ACC_W-1:0]              col_lo;
   logic [sbgr_pkg::DIM_W-1:0]    gap;

   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [sbgr_pkg::SAMPLE_W-1:0] ram_wdata;
   logic [sbgr_pkg::SAMPLE_W-1:0] ram_rdata;

   logic                          div_start;
   logic [DVD_W-1:0]              div_dividend;
   logic [DVS_W-1:0]              div_divisor;
   logic                          div_done;
   logic [DVD_W-1:0]              div_quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff    <= sbgr_pkg::MAX_VALUE_RESET;
         graph_width_ff  <= sbgr_pkg::GRAPH_WIDTH_RESET;
         graph_height_ff <= sbgr_pkg::GRAPH_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sbgr_pkg::REG_MAX_VALUE: begin
               max_value_ff <= csr_write_data;
            end
            sbgr_pkg::REG_GRAPH_WIDTH: begin
               graph_width_ff <= csr_write_data[sbgr_pkg::DIM_W-1:0];
            end
            sbgr_pkg::REG_GRAPH_HEIGHT: begin
               graph_height_ff <= csr_write_data[sbgr_pkg::DIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign oldest_next = (oldest_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : oldest_ff + AW'(1);

   // Physical slot of logical entry idx, oldest first.
   assign slot_sum = {1'b0, oldest_ff} + {1'b0, idx_ff};
   assign slot     = (slot_sum >= (AW+1)'(HISTORY_DEPTH)) ?
                     AW'(slot_sum - (AW+1)'(HISTORY_DEPTH)) : AW'(slot_sum);

   // Entry i belongs to column c when c*depth <= i*width < (c+1)*depth.
   assign col_lo = ACC_W'(req_column) * ACC_W'(HISTORY_DEPTH);
   assign gap    = graph_height_ff - sbgr_pkg::DIM_W'(row_ff);

   always_comb begin
      state_in              = state_ff;
      idx_in                = idx_ff;
      oldest_in             = oldest_ff;
      acc_in                = acc_ff;
      lo_in                 = lo_ff;
      hi_in                 = hi_ff;
      match_in              = 1'b0;
      sum_in                = sum_ff;
      count_in              = count_ff;
      avg_in                = avg_ff;
      prod_in               = prod_ff;
      row_in                = row_ff;
      lit_in                = lit_ff;
      rsp_valid_in          = rsp_valid_ff;
      rsp_pixel_lit_in      = rsp_pixel_lit_ff;
      rsp_column_average_in = rsp_column_average_ff;
      ram_we                = 1'b0;
      ram_waddr             = oldest_ff;
      ram_wdata             = req_sample;
      div_start             = 1'b0;
      div_dividend          = DVD_W'(sum_ff);
      div_divisor           = DVS_W'(count_ff);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Read data arrives in the cycle after the address, so the match flag is registered to line up with it.
      if (match_ff) begin
         sum_in   = sum_ff + SUM_W'(ram_rdata);
         count_in = count_ff + CNT_W'(1);
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = '0;
            idx_in    = idx_ff + AW'(1);
            if (idx_ff == AW'(HISTORY_DEPTH - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == sbgr_pkg::MODE_PUSH) begin
                  ram_we    = 1'b1;
                  oldest_in = oldest_next;
               end else begin
                  row_in   = req_row;
                  lo_in    = col_lo;
                  hi_in    = col_lo + ACC_W'(HISTORY_DEPTH);
                  idx_in   = '0;
                  acc_in   = '0;
                  sum_in   = '0;
                  count_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            match_in = (acc_ff >= lo_ff) && (acc_ff < hi_ff);
            acc_in   = acc_ff + ACC_W'(graph_width_ff);
            idx_in   = idx_ff + AW'(1);
            // The running product only grows, so nothing past the column can match.
            if ((idx_ff == AW'(HISTORY_DEPTH - 1)) || (acc_ff >= hi_ff)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_AVG;
         end
         ST_AVG: begin
            if (count_ff == '0) begin
               avg_in   = '0;
               state_in = ST_MUL;
            end else begin
               div_start = 1'b1;
               state_in  = ST_AVG_WAIT;
            end
         end
         ST_AVG_WAIT: begin
            if (div_done) begin
               avg_in   = div_quotient[sbgr_pkg::SAMPLE_W-1:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(avg_ff) * PROD_W'(graph_height_ff);
            state_in = ST_BAR;
         end
         ST_BAR: begin
            div_dividend = DVD_W'(prod_ff);
            div_divisor  = DVS_W'(max_value_ff);
            if ((max_value_ff == '0) ||
                (sbgr_pkg::DIM_W'(row_ff) >= graph_height_ff)) begin
               lit_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_BAR_WAIT;
            end
         end
         ST_BAR_WAIT: begin
            div_dividend = DVD_W'(prod_ff);
            div_divisor  = DVS_W'(max_value_ff);
            if (div_done) begin
               lit_in   = (DVD_W'(gap) < div_quotient);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_pixel_lit_in      = lit_ff;
               rsp_column_average_in = avg_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         oldest_ff    <= '0;
         match_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         oldest_ff    <= oldest_in;
         match_ff     <= match_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff                <= acc_in;
      lo_ff                 <= lo_in;
      hi_ff                 <= hi_in;
      sum_ff                <= sum_in;
      avg_ff                <= avg_in;
      prod_ff               <= prod_in;
      row_ff                <= row_in;
      lit_ff                <= lit_in;
      rsp_pixel_lit_ff      <= rsp_pixel_lit_in;
      rsp_column_average_ff <= rsp_column_average_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_lit      = rsp_pixel_lit_ff;
   assign rsp_column_average = rsp_column_average_ff;

   sbgr_ram #(
      .WIDTH (sbgr_pkg::SAMPLE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (slot),
      .read_data     (ram_rdata)
   );

   sbgr_divider #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   `SBGR_ASSERT_NEXT(a_push_advances, clock, reset, req_accept && (req_mode == sbgr_pkg::MODE_PUSH), oldest_ff == $past(oldest_next), "push did not advance the oldest pointer")
   `SBGR_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(HISTORY_DEPTH), "column sample count exceeds the history depth")
   `SBGR_ASSERT_IMPLIES(a_div_nonzero, clock, reset, div_start, div_divisor != '0, "divider started with a zero divisor")
   `SBGR_ASSERT_IMPLIES(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "response raised outside the done state")

endmodule

// File: rtl/sbgr_ram.sv
module sbgr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_address,
   input  logic [WIDTH-1:0]  write_data,
   input  logic [ADDR_W-1:0] read_address,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// File: rtl/sbgr_divider.sv
module sbgr_divider #(
   parameter int DVD_W = 29,
   parameter int DVS_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W:0]    shifted;

   // One quotient bit per cycle, most significant first (restoring division).
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(shifted - {1'b0, dvs_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = DVS_W'(shifted);
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: bench/tb.sv
module tb;

   localparam int DEPTH          = sbgr_pkg::DEFAULT_HISTORY_DEPTH;
   localparam int SETTLE_CYCLES  = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASES         = 8;
   localparam int ITEMS_PER_PHASE = 150;
   localparam logic [sbgr_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic                          lit;
      logic [sbgr_pkg::SAMPLE_W-1:0] avg;
   } pixel_type;

   typedef struct {
      logic                          mode;
      logic [sbgr_pkg::SAMPLE_W-1:0] sample;
      logic [sbgr_pkg::COORD_W-1:0]  column;
      logic [sbgr_pkg::COORD_W-1:0]  row;
      bit                            known;
      pixel_type                     want;
   } script_row_type;

   localparam int SCRIPT_LEN = 14;

   // Rows with a typed-in pixel assume the reset geometry: one sample per column.
   script_row_type script [SCRIPT_LEN] = '{
      '{sbgr_pkg::MODE_QUERY, 16'd0,    10'd0,    10'd0,    1'b1, '{1'b0, 16'd0}},
      '{sbgr_pkg::MODE_QUERY, 16'hFFFF, 10'd1023, 10'd1023, 1'b1, '{1'b0, 16'd0}},
      '{sbgr_pkg::MODE_QUERY, 16'd0,    10'd0,    10'd1023, 1'b1, '{1'b0, 16'd0}},
      '{sbgr_pkg::MODE_PUSH,  16'hFFFF, 10'd1023, 10'd1023, 1'b0, '{1'b0, 16'd0}},
      '{sbgr_pkg::MODE_QUERY, 16'd0,    10'd255,  10'd0,    1'b1, '{1'b0, 16'hFFFF}},
      '{sbgr_pkg::MODE_QUERY, 16'd0,    10'd255,  10'd1,    1'b1, '{1'b1, 16'hFFFF}},
      '{sbgr_pkg::MODE_QUERY, 16'd0,    10'd255,  10'd255,  1'b1, '{1'b1, 16'hFFFF}},
      '{sbgr_pkg::MODE_QUERY, 16'd0,    10'd255,  10'd256,  1'b1, '{1'b0, 16'hFFFF}},
      '{sbgr_pkg::MODE_PUSH,  16'd0,    10'd0,    10'd0,    1'b0, '{1'b0, 16'd0}},
      '{sbgr_pkg::MODE_QUERY, 16'd0,    10'd254,  10'd128,  1'b1, '{1'b1, 16'hFFFF}},
      '{sbgr_pkg::MODE_PUSH,  16'h8000, 10'd0,    10'd0,    1'b0, '{1'b0, 16'd0}},
      '{sbgr_pkg::MODE_PUSH,  16'd1,    10'd0,    10'd0,    1'b0, '{1'b0, 16'd0}},
      '{sbgr_pkg::MODE_QUERY, 16'd0,    10'd254,  10'd200,  1'b0, '{1'b0, 16'd0}},
      '{sbgr_pkg::MODE_QUERY, 16'd0,    10'd253,  10'd100,  1'b0, '{1'b0, 16'd0}}
   };

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_mode;
   logic [sbgr_pkg::SAMPLE_W-1:0]        req_sample;
   logic [sbgr_pkg::COORD_W-1:0]         req_column;
   logic [sbgr_pkg::COORD_W-1:0]         req_row;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic                                 rsp_pixel_lit;
   logic [sbgr_pkg::SAMPLE_W-1:0]        rsp_column_average;
   logic                                 csr_write_enable;
   logic [sbgr_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [sbgr_pkg::CSR_DATA_W-1:0]      csr_write_data;

   scrolling_bar_graph_renderer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_sample         (req_sample),
      .req_column         (req_column),
      .req_row            (req_row),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_lit      (rsp_pixel_lit),
      .rsp_column_average (rsp_column_average),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #6 clock = ~clock;

   // Shadow of the block: sample history and graph geometry.
   logic [sbgr_pkg::SAMPLE_W-1:0] history [DEPTH];
   int unsigned                   oldest_slot;
   int unsigned                   cfg_max;
   int unsigned                   cfg_width;
   int unsigned                   cfg_height;

   pixel_type pending_pixels [$];
   int        errors;
   int        quiet_cycles;
   bit        req_taken;
   bit        cur_known;
   pixel_type cur_want;
   int        burst_left;

   function automatic pixel_type render_pixel(logic [sbgr_pkg::COORD_W-1:0] col,
                                              logic [sbgr_pkg::COORD_W-1:0] r);
      longint unsigned sum;
      longint unsigned bar;
      int unsigned     count;
      int unsigned     owner;
      int unsigned     average;
      int unsigned     gap;
      pixel_type       p;
      sum   = 0;
      count = 0;
      for (int i = 0; i < DEPTH; i++) begin
         owner = (i * cfg_width) / DEPTH;
         if (owner == 32'(col)) begin
            sum += 64'(history[(oldest_slot + i) % DEPTH]);
            count++;
         end
      end
      average = (count == 0) ? 0 : 32'(sum / 64'(count));
      p.avg = average[sbgr_pkg::SAMPLE_W-1:0];
      p.lit = 1'b0;
      if (32'(r) < cfg_height && cfg_max != 0) begin
         gap   = cfg_height - 32'(r);
         bar   = (64'(average) * 64'(cfg_height)) / 64'(cfg_max);
         p.lit = (64'(gap) < bar);
      end
      return p;
   endfunction

   always @(posedge clock) begin : monitor
      pixel_type want;
      pixel_type got;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) history[i] = '0;
         oldest_slot  = 0;
         cfg_max      = 32'(sbgr_pkg::MAX_VALUE_RESET);
         cfg_width    = 32'(sbgr_pkg::GRAPH_WIDTH_RESET);
         cfg_height   = 32'(sbgr_pkg::GRAPH_HEIGHT_RESET);
         quiet_cycles = 0;
         req_taken   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               sbgr_pkg::REG_MAX_VALUE:    cfg_max    = 32'(csr_write_data);
               sbgr_pkg::REG_GRAPH_WIDTH:
                  cfg_width  = 32'(csr_write_data[sbgr_pkg::DIM_W-1:0]);
               sbgr_pkg::REG_GRAPH_HEIGHT:
                  cfg_height = 32'(csr_write_data[sbgr_pkg::DIM_W-1:0]);
               default: ;
            endcase
         end
         // A result taken at this edge belongs to an older request, so check it first.
         if (rsp_valid && !rsp_stall) begin
            got.lit = rsp_pixel_lit;
            got.avg = rsp_column_average;
            if (pending_pixels.size() == 0) begin
               $error("unexpected result: pixel_lit %0d column_average %0d", got.lit, got.avg);
               errors++;
            end else begin
               want = pending_pixels[0];
               pending_pixels.delete(0);
               if (got.lit !== want.lit) begin
                  $error("pixel_lit: expected %0d, got %0d", want.lit, got.lit);
                  errors++;
               end
               if (got.avg !== want.avg) begin
                  $error("column_average: expected %0d, got %0d", want.avg, got.avg);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_mode == sbgr_pkg::MODE_PUSH) begin
               history[oldest_slot] = req_sample;
               oldest_slot = (oldest_slot + 1) % DEPTH;
            end else begin
               want = render_pixel(req_column, req_row);
               if (cur_known) want = cur_want;
               pending_pixels.insert(pending_pixels.size(), want);
            end
         end
         req_taken <= req_valid && !req_stall;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   // The receiver moves between free flow, light and heavy random stalls and a fixed rhythm.
   int stall_style;
   int stall_left;
   int stall_tick;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left  = $urandom_range(50, 300);
      end
      stall_left--;
      stall_tick++;
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_tick % 16) < 10);
      endcase
   end

   task automatic send_request(logic mode, logic [sbgr_pkg::SAMPLE_W-1:0] sample,
                               logic [sbgr_pkg::COORD_W-1:0] column,
                               logic [sbgr_pkg::COORD_W-1:0] row,
                               bit known, pixel_type want);
      int gap;
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_sample <= sample;
      req_column <= column;
      req_row    <= row;
      cur_known  <= known;
      cur_want   <= want;
      do @(negedge clock); while (!req_taken);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Wait until every query has answered and any trailing push has retired.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_geometry(int unsigned max_value, int unsigned width,
                                   int unsigned height, bit poke_unused);
      if (poke_unused) begin
         csr_write_enable <= 1'b1;
         csr_index        <= REG_UNUSED;
         csr_write_data   <= 16'hFFFF;
         @(negedge clock);
      end
      csr_write_enable <= 1'b1;
      csr_index        <= sbgr_pkg::REG_MAX_VALUE;
      csr_write_data   <= max_value[sbgr_pkg::CSR_DATA_W-1:0];
      @(negedge clock);
      csr_index        <= sbgr_pkg::REG_GRAPH_WIDTH;
      csr_write_data   <= width[sbgr_pkg::CSR_DATA_W-1:0];
      @(negedge clock);
      csr_index        <= sbgr_pkg::REG_GRAPH_HEIGHT;
      csr_write_data   <= height[sbgr_pkg::CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_request;
      logic                          mode;
      logic [sbgr_pkg::SAMPLE_W-1:0] sample;
      logic [sbgr_pkg::COORD_W-1:0]  column;
      logic [sbgr_pkg::COORD_W-1:0]  row;
      int unsigned                   top;
      mode = 1'($urandom_range(0, 1));
      // Most samples lie between zero and about twice the full-scale value so that bars often land inside the graph.
      if ($urandom_range(0, 3) == 0)
         sample = sbgr_pkg::SAMPLE_W'($urandom_range(0, 65535));
      else begin
         top    = (cfg_max * 2 + 16 > 65535) ? 65535 : cfg_max * 2 + 16;
         sample = sbgr_pkg::SAMPLE_W'($urandom_range(0, top));
      end
      if ($urandom_range(0, 4) == 0)
         column = sbgr_pkg::COORD_W'($urandom_range(0, 1023));
      else begin
         top    = (cfg_width == 0) ? 0 : ((cfg_width > 1024) ? 1023 : cfg_width - 1);
         column = sbgr_pkg::COORD_W'($urandom_range(0, top));
      end
      if ($urandom_range(0, 4) == 0)
         row = sbgr_pkg::COORD_W'($urandom_range(0, 1023));
      else begin
         top = (cfg_height == 0) ? 0 : ((cfg_height > 1024) ? 1023 : cfg_height - 1);
         row = sbgr_pkg::COORD_W'($urandom_range(0, top));
      end
      send_request(mode, sample, column, row, 1'b0, '0);
   endtask

   int unsigned phase_max    [PHASES];
   int unsigned phase_width  [PHASES];
   int unsigned phase_height [PHASES];

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = sbgr_pkg::MODE_PUSH;
      req_sample       = '0;
      req_column       = '0;
      req_row          = '0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = sbgr_pkg::REG_MAX_VALUE;
      csr_write_data   = '0;
      cur_known        = 1'b0;
      cur_want         = '0;
      errors           = 0;
      stall_left       = 0;
      stall_tick       = 0;
      burst_left       = $urandom_range(1, 24);

      phase_max    = '{65535, 1,    0,   1000, 300, 65535, 0, 0};
      phase_width  = '{1,     1024, 0,   2047, 7,   256,   0, 0};
      phase_height = '{1024,  1,    256, 2047, 50,  1,     0, 0};
      for (int k = PHASES - 2; k < PHASES; k++) begin
         phase_max[k]    = $urandom_range(1, 65535);
         phase_width[k]  = $urandom_range(1, 1024);
         phase_height[k] = $urandom_range(1, 1024);
      end

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (script[k])
         send_request(script[k].mode, script[k].sample, script[k].column, script[k].row,
                      script[k].known, script[k].want);

      for (int k = 0; k < PHASES; k++) begin
         drain();
         program_geometry(phase_max[k], phase_width[k], phase_height[k], k == 0);
         repeat (ITEMS_PER_PHASE) random_request();
      end

      drain();
      if (errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
